[hdl/ppf_pkg.sv]
// ----------------------------------------------------------------------------
// ppf_pkg
// Shared constants, state encoding and controller/datapath link types for the
// partition pivot finder.
// ----------------------------------------------------------------------------
package ppf_pkg;

  localparam int DATA_W     = 32;
  localparam int MAX_ITEMS  = 1024;
  localparam int ADDR_W     = $clog2(MAX_ITEMS);
  localparam int CNT_W      = ADDR_W + 1;
  localparam int LIST_LIMIT = 63;
  localparam int LIST_W     = $clog2(LIST_LIMIT + 1);

  localparam logic KIND_COUNT = 1'b0;
  localparam logic KIND_VALUE = 1'b1;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_BACK,
    ST_BACK_DRAIN,
    ST_FWD,
    ST_FWD_DRAIN,
    ST_SEND_CNT,
    ST_LIST_RD,
    ST_LIST_PUT
  } ppf_state_t;

  typedef struct packed {
    logic load;
    logic back_issue;
    logic fwd_init;
    logic fwd_issue;
    logic out_count;
    logic list_issue;
    logic out_list;
    logic finish;
  } ppf_cmd_t;

  typedef struct packed {
    logic idx_zero;
    logic idx_at_end;
    logic out_free;
    logic shown_zero;
    logic list_last;
  } ppf_sts_t;

endpackage

[hdl/ppf_if.sv]
// ----------------------------------------------------------------------------
// ppf_if
// Valid/ready channel interfaces for sequence elements and scan results.
// ----------------------------------------------------------------------------
interface ppf_elem_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic               final_item;

  modport source (output valid, output value, output final_item, input ready);
  modport sink (input valid, input value, input final_item, output ready);
endinterface

interface ppf_result_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic signed [31:0] payload;
  logic               overflowed;
  logic               end_of_run;

  modport source (output valid, output kind, output payload, output overflowed,
                  output end_of_run, input ready);
  modport sink (input valid, input kind, input payload, input overflowed,
                input end_of_run, output ready);
endinterface

[hdl/ppf_ctrl.sv]
// ----------------------------------------------------------------------------
// ppf_ctrl
// Sequencer for load, backward suffix-min pass, forward pivot pass and
// result emission.
// ----------------------------------------------------------------------------
module ppf_ctrl
  import ppf_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     elem_valid,
  input  logic     elem_final,
  output logic     elem_ready,
  input  ppf_sts_t sts,
  output ppf_cmd_t cmd
);

  ppf_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: begin
        if (elem_valid && elem_final) state_next = ST_BACK;
      end
      ST_BACK: begin
        if (sts.idx_zero) state_next = ST_BACK_DRAIN;
      end
      ST_BACK_DRAIN: state_next = ST_FWD;
      ST_FWD: begin
        if (sts.idx_at_end) state_next = ST_FWD_DRAIN;
      end
      ST_FWD_DRAIN: state_next = ST_SEND_CNT;
      ST_SEND_CNT: begin
        if (sts.out_free) state_next = sts.shown_zero ? ST_LOAD : ST_LIST_RD;
      end
      ST_LIST_RD: state_next = ST_LIST_PUT;
      ST_LIST_PUT: begin
        if (sts.out_free) state_next = sts.list_last ? ST_LOAD : ST_LIST_RD;
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_comb begin
    cmd        = '0;
    elem_ready = 1'b0;
    unique case (state)
      ST_LOAD: begin
        elem_ready = 1'b1;
        cmd.load   = elem_valid;
      end
      ST_BACK:       cmd.back_issue = 1'b1;
      ST_BACK_DRAIN: cmd.fwd_init = 1'b1;
      ST_FWD:        cmd.fwd_issue = 1'b1;
      ST_FWD_DRAIN:  cmd = '0;
      ST_SEND_CNT: begin
        cmd.out_count = sts.out_free;
        cmd.finish    = sts.out_free && sts.shown_zero;
      end
      ST_LIST_RD:    cmd.list_issue = 1'b1;
      ST_LIST_PUT: begin
        cmd.out_list = sts.out_free;
        cmd.finish   = sts.out_free && sts.list_last;
      end
      default: cmd = '0;
    endcase
  end

endmodule

[hdl/ppf_datapath.sv]
// ----------------------------------------------------------------------------
// ppf_datapath
// Element, suffix-min and pivot list memories, scan pipelines, counters and
// the result output register.
// ----------------------------------------------------------------------------
module ppf_datapath
  import ppf_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  ppf_cmd_t                 cmd,
  output ppf_sts_t                 sts,
  input  logic signed [DATA_W-1:0] elem_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_kind,
  output logic signed [DATA_W-1:0] out_payload,
  output logic                     out_overflowed,
  output logic                     out_end_of_run
);

  logic signed [DATA_W-1:0] elem_mem   [MAX_ITEMS];
  logic signed [DATA_W-1:0] suffix_mem [MAX_ITEMS];
  logic signed [DATA_W-1:0] list_mem   [LIST_LIMIT];

  logic [CNT_W-1:0]  cnt;
  logic              ovf;
  logic [ADDR_W-1:0] idx;
  logic [ADDR_W-1:0] nm1;
  logic [CNT_W-1:0]  found;
  logic [LIST_W-1:0] k;
  logic [LIST_W-1:0] shown;

  logic              bp_valid;
  logic              bp_first;
  logic [ADDR_W-1:0] bp_idx;
  logic signed [DATA_W-1:0] running_min;
  logic signed [DATA_W-1:0] min_next;

  logic              fp_valid;
  logic              fp_first;
  logic              fp_last;
  logic signed [DATA_W-1:0] running_max;
  logic              is_pivot;

  logic signed [DATA_W-1:0] elem_rd;
  logic signed [DATA_W-1:0] suffix_rd;
  logic signed [DATA_W-1:0] list_rd;

  logic store_full;

  assign store_full = (cnt == CNT_W'(MAX_ITEMS));
  assign shown = (found >= CNT_W'(LIST_LIMIT)) ? LIST_W'(LIST_LIMIT) : found[LIST_W-1:0];

  assign sts.idx_zero   = (idx == '0);
  assign sts.idx_at_end = (idx == nm1);
  assign sts.out_free   = !out_valid || out_ready;
  assign sts.shown_zero = (found == '0);
  assign sts.list_last  = (LIST_W'(k + 1'b1) == shown);

  // Element store: written while loading, read by both scan passes.
  always_ff @(posedge clk) begin
    if (cmd.load && !store_full) begin
      elem_mem[cnt[ADDR_W-1:0]] <= elem_value;
    end
    if (cmd.back_issue || cmd.fwd_issue) begin
      elem_rd <= elem_mem[idx];
    end
  end

  assign min_next = (bp_first || elem_rd < running_min) ? elem_rd : running_min;

  always_ff @(posedge clk) begin
    if (bp_valid) begin
      suffix_mem[bp_idx] <= min_next;
    end
    if (cmd.fwd_issue) begin
      suffix_rd <= suffix_mem[ADDR_W'(idx + 1'b1)];
    end
  end

  assign is_pivot = (fp_first || elem_rd >= running_max) &&
                    (fp_last || elem_rd < suffix_rd);

  always_ff @(posedge clk) begin
    if (fp_valid && is_pivot && found < CNT_W'(LIST_LIMIT)) begin
      list_mem[found[LIST_W-1:0]] <= elem_rd;
    end
    if (cmd.list_issue) begin
      list_rd <= list_mem[k];
    end
  end

  // Load counters and scan index.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      ovf <= 1'b0;
    end else if (cmd.finish) begin
      cnt <= '0;
      ovf <= 1'b0;
    end else if (cmd.load) begin
      if (store_full) begin
        ovf <= 1'b1;
      end else begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && !store_full) begin
      nm1 <= cnt[ADDR_W-1:0];
      idx <= cnt[ADDR_W-1:0];
    end else if (cmd.back_issue) begin
      idx <= idx - 1'b1;
    end else if (cmd.fwd_init) begin
      idx <= '0;
    end else if (cmd.fwd_issue) begin
      idx <= idx + 1'b1;
    end
  end

  // Backward pass pipeline: read element, then fold into the running minimum.
  always_ff @(posedge clk) begin
    if (rst) begin
      bp_valid <= 1'b0;
    end else begin
      bp_valid <= cmd.back_issue;
    end
  end

  always_ff @(posedge clk) begin
    bp_first <= (idx == nm1);
    bp_idx   <= idx;
    if (bp_valid) begin
      running_min <= min_next;
    end
  end

  // Forward pass pipeline: pivot test against prefix max and suffix min.
  always_ff @(posedge clk) begin
    if (rst) begin
      fp_valid <= 1'b0;
    end else begin
      fp_valid <= cmd.fwd_issue;
    end
  end

  always_ff @(posedge clk) begin
    fp_first <= (idx == '0);
    fp_last  <= (idx == nm1);
    if (fp_valid && (fp_first || elem_rd > running_max)) begin
      running_max <= elem_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= '0;
      k     <= '0;
    end else if (cmd.finish) begin
      found <= '0;
      k     <= '0;
    end else begin
      if (fp_valid && is_pivot) begin
        found <= found + 1'b1;
      end
      if (cmd.out_list) begin
        k <= k + 1'b1;
      end
    end
  end

  // Result register; a new request is loaded only when the slot is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_count || cmd.out_list) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_count) begin
      out_kind       <= KIND_COUNT;
      out_payload    <= DATA_W'(found);
      out_overflowed <= ovf;
      out_end_of_run <= sts.shown_zero;
    end else if (cmd.out_list) begin
      out_kind       <= KIND_VALUE;
      out_payload    <= list_rd;
      out_overflowed <= ovf;
      out_end_of_run <= sts.list_last;
    end
  end

endmodule

[hdl/partition_pivot_finder_top.sv]
// ----------------------------------------------------------------------------
// partition_pivot_finder_top
// Finds every element of a loaded sequence that is at least the maximum of all
// earlier elements and below the minimum of all later ones.
// ----------------------------------------------------------------------------
// Usage:
//   The elem channel takes one signed 32-bit element per request, one per
//   cycle while loading; final_item marks the last element of a sequence.
//   Up to 1024 elements are stored; later ones are dropped and flagged.
//   After the final element the block runs a backward suffix-min pass and
//   a forward pivot pass over the element memory (one read port each
//   cycle), then sends on the result channel a count request followed by
//   up to 63 pivot values, each read from the pivot list before it is
//   loaded into the output register, the last one with end_of_run set.
//   overflowed repeats on every result. elem.ready is low from the final
//   element until the last result has been loaded into the output register.
//   A stalled receiver holds the output register and pauses emission; the
//   next sequence may start loading while the last result still waits.
//   Reset (rst, synchronous) empties the store and the output register.
// ----------------------------------------------------------------------------
module partition_pivot_finder_top
  import ppf_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  ppf_elem_if.sink            elem,
  ppf_result_if.source        result
);

  ppf_cmd_t cmd;
  ppf_sts_t sts;

  ppf_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .elem_valid (elem.valid),
    .elem_final (elem.final_item),
    .elem_ready (elem.ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  ppf_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .elem_value     (elem.value),
    .out_valid      (result.valid),
    .out_ready      (result.ready),
    .out_kind       (result.kind),
    .out_payload    (result.payload),
    .out_overflowed (result.overflowed),
    .out_end_of_run (result.end_of_run)
  );

endmodule
